@@ hw/rtl/rea_pkg.sv @@
// Shared constants, codes and control types of the rotary encoder accelerator.
package rea_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF     = 16;
    localparam int CFG_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH    = 1;
    localparam int DELTA_WIDTH        = 8;
    localparam int STEP_WIDTH         = CFG_WIDTH + 1;
    localparam int DIV_STEPS          = CFG_WIDTH;
    localparam int DIV_CNT_WIDTH      = $clog2(DIV_STEPS);

    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] ACCEL_RESET   = 16'd200;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TIMEOUT_MS   = 1'b0,
        CFG_ACCEL_FACTOR = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic accel;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/rea_if.sv @@
// Request and result channel interfaces of the rotary encoder accelerator.
interface rea_in_if;
    import rea_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [DELTA_WIDTH-1:0] delta;

    modport source (output valid, output req_type, output delta, input ready);
    modport sink   (input valid, input req_type, input delta, output ready);
endinterface

interface rea_out_if #(
    parameter int POSITION_WIDTH = rea_pkg::POSITION_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] position;
    logic                             accelerated;

    modport source (output valid, output position, output accelerated, input ready);
    modport sink   (input valid, input position, input accelerated, output ready);
endinterface

@@ hw/rtl/rea_ctrl.sv @@
// Controller state machine that sequences decide, divide and commit per request.
module rea_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output rea_pkg::t_dp_cmd    o_cmd,
    input  rea_pkg::t_dp_status i_status
);
    import rea_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the current state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through decide, optional division and commit
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = i_status.accel ? ST_DIV : ST_WRITE;
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.div_init = i_status.accel;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/rea_datapath.sv @@
// Datapath: configuration, position and elapsed state, divider and result register.
module rea_datapath #(
    parameter int POSITION_WIDTH = rea_pkg::POSITION_WIDTH_DEF,
    parameter int TIME_WIDTH     = rea_pkg::TIME_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  rea_pkg::t_dp_cmd                        i_cmd,
    output rea_pkg::t_dp_status                     o_status,
    input  logic                                    i_req_type,
    input  logic signed [rea_pkg::DELTA_WIDTH-1:0]  i_delta,
    input  logic                                    i_cfg_we,
    input  logic [rea_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_addr,
    input  logic [rea_pkg::CFG_WIDTH-1:0]           i_cfg_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [POSITION_WIDTH-1:0]        o_position,
    output logic                                    o_accelerated
);
    import rea_pkg::*;

    // Configuration
    logic [CFG_WIDTH-1:0]      r_timeout;
    logic [CFG_WIDTH-1:0]      r_accel_factor;

    // Captured request
    logic                      r_req_type;
    logic [DELTA_WIDTH-1:0]    r_delta;

    // Architectural state
    logic [POSITION_WIDTH-1:0] r_position;
    logic [POSITION_WIDTH-1:0] n_position;
    logic [TIME_WIDTH-1:0]     r_elapsed;
    logic [TIME_WIDTH-1:0]     n_elapsed;

    // Divider
    logic [CFG_WIDTH-1:0]      r_quot;
    logic [TIME_WIDTH-1:0]     r_rem;
    logic [DIV_CNT_WIDTH-1:0]  r_div_cnt;
    logic [TIME_WIDTH-1:0]     divisor;
    logic [TIME_WIDTH:0]       trial;
    logic                      trial_fits;

    // Result register
    logic                      r_out_valid;
    logic [POSITION_WIDTH-1:0] r_out_pos;
    logic                      r_out_accel;

    logic                      neg;
    logic [DELTA_WIDTH-1:0]    mag;
    logic                      moves;
    logic                      accel;
    logic [STEP_WIDTH-1:0]     step;
    logic [POSITION_WIDTH-1:0] step_ext;

    // Decode the captured request
    always_comb begin
        neg      = r_delta[DELTA_WIDTH-1];
        mag      = neg ? (~r_delta + DELTA_WIDTH'(1)) : r_delta;
        moves    = (r_req_type == REQ_POLL) && (mag != '0);
        accel    = moves && (32'(r_elapsed) < 32'(r_timeout));
        step     = STEP_WIDTH'(mag) + (accel ? STEP_WIDTH'(r_quot) : STEP_WIDTH'(0));
        step_ext = POSITION_WIDTH'(step);
    end

    // Restoring division step: one quotient bit per cycle
    always_comb begin
        divisor    = (r_elapsed == '0) ? TIME_WIDTH'(1) : r_elapsed;
        trial      = {r_rem, r_quot[CFG_WIDTH-1]};
        trial_fits = trial >= {1'b0, divisor};
    end

    // Next position and elapsed count
    always_comb begin
        n_position = r_position;
        n_elapsed  = r_elapsed;
        if (r_req_type == REQ_TICK) begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + TIME_WIDTH'(1);
            end
        end else if (moves) begin
            n_position = neg ? (r_position - step_ext) : (r_position + step_ext);
            n_elapsed  = '0;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= TIMEOUT_RESET;
            r_accel_factor <= ACCEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TIMEOUT_MS:   r_timeout      <= i_cfg_data;
                CFG_ACCEL_FACTOR: r_accel_factor <= i_cfg_data;
                default: begin
                    r_timeout <= r_timeout;
                end
            endcase
        end
    end

    // Capture the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_delta    <= i_delta;
        end
    end

    // Run the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quot    <= r_accel_factor;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[CFG_WIDTH-2:0], trial_fits};
            r_rem     <= trial_fits ? TIME_WIDTH'(trial - {1'b0, divisor})
                                    : trial[TIME_WIDTH-1:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_WIDTH'(1);
        end
    end

    // Commit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_elapsed  <= '0;
        end else if (i_cmd.commit) begin
            r_position <= n_position;
            r_elapsed  <= n_elapsed;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_pos   <= n_position;
            r_out_accel <= accel;
        end
    end

    assign o_status.accel    = accel;
    assign o_status.div_last = r_div_cnt == DIV_CNT_WIDTH'(DIV_STEPS - 1);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_accelerated = r_out_accel;

endmodule

@@ hw/rtl/rotary_encoder_accelerator.sv @@
// Top level of the rotary encoder accelerator: controller, datapath and channel hookup.
//
//   Port     Dir  Handshake     Carries
//   i_in     in   valid/ready   req_type (tick or poll), delta
//   o_out    out  valid/ready   position, accelerated
//   i_cfg_*  in   write enable  register index, 16-bit data
//
// A tick or an unaccelerated poll passes through the decide and write states before
// its result shows; an accelerated poll also runs the 16-step restoring divider,
// which forms accel_factor / elapsed one quotient bit per cycle, between the two.
// The next request can be accepted in the cycle in which the result appears.
// One request is in work at a time; the result register lets the next request
// be accepted while a result waits. A stalled result holds the commit step.
// Reset (synchronous, active low) clears position and elapsed count and loads
// timeout 500 and accel_factor 200.
module rotary_encoder_accelerator #(
    parameter int POSITION_WIDTH = rea_pkg::POSITION_WIDTH_DEF,
    parameter int TIME_WIDTH     = rea_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rea_in_if.sink                              i_in,
    rea_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [rea_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_addr,
    input  logic [rea_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import rea_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    rea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rea_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_in.req_type),
        .i_delta       (i_in.delta),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_position    (o_out.position),
        .o_accelerated (o_out.accelerated)
    );

    assign i_in.ready = in_ready;

endmodule
